>>> rtl/core/fsmk_pkg.sv
`timescale 1ns / 1ps

package fsmk_pkg;

	localparam int unsigned CfgW  = 7;
	localparam int unsigned ProcW = 8;
	localparam int unsigned TimeW = 32;

	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

	// per-operation flags from the sequencer to the datapath
	typedef struct packed {
		logic first;
		logic done;
	} seq_flags_t;

endpackage

>>> rtl/core/fsmk_ram.sv
`timescale 1ns / 1ps

module fsmk_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/core/fsmk_seq.sv
`timescale 1ns / 1ps

module fsmk_seq #(
	parameter int unsigned MAX_MACHINES = 64
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic                                  restart,
	input  logic [fsmk_pkg::CfgW-1:0]             machine_count,
	output logic [((MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1)-1:0] idx,
	output fsmk_pkg::seq_flags_t                  flags
);

	localparam int unsigned IW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam int unsigned MW = IW + 1;
	localparam logic [MW-1:0] MaxM = MW'(MAX_MACHINES);

	logic [IW-1:0] idx_q;
	logic          first_q;
	logic [MW-1:0] m_eff;
	logic [IW-1:0] idx_base;

	always_comb begin
		if (machine_count == '0) begin
			m_eff = MW'(1);
		end else if (32'(machine_count) > MAX_MACHINES) begin
			m_eff = MaxM;
		end else begin
			m_eff = MW'(machine_count);
		end
	end

	always_comb begin
		idx_base = restart ? '0 : idx_q;
		// count lowered mid-job: start over at machine 0
		if ({1'b0, idx_base} >= m_eff) begin
			idx = '0;
		end else begin
			idx = idx_base;
		end
		flags.first = restart | first_q;
		flags.done  = ({1'b0, idx} == (m_eff - MW'(1)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (flags.done) begin
				idx_q   <= '0;
				first_q <= 1'b0;
			end else begin
				idx_q   <= idx + IW'(1);
				first_q <= flags.first;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && flags.done) |=> (idx_q == '0 && !first_q))
		else $error("sequencer did not wrap after last machine");

endmodule

>>> rtl/core/flow_shop_makespan_top.sv
`timescale 1ns / 1ps

// permutation flow shop completion-time engine
// s_* carries processing times job by job, machines in order within a job;
// s_tuser high marks the first operation of a new schedule.
// m_* returns one completion time per operation; m_tlast marks the last
// machine of a job, so the last m_tlast result of a schedule is the makespan.
// cfg_we/cfg_wdata set the machine count (0 acts as 1, above MAX_MACHINES
// acts as MAX_MACHINES); write it only while the block is idle.
// one item per cycle sustained while m_tready stays high; the previous-job
// row memory is read at the input transfer edge, and the max/add lands in the
// output register when the read stage advances into it;
// a same-entry write in the compute stage is forwarded to the read stage.
// when m_tready is low the output register holds and the read stage fills;
// s_tready then drops until the output register frees up.
// reset is asynchronous: machine index and schedule state clear and per-entry
// valid flags mark the whole row as zero, so no clearing pass is needed.
module flow_shop_makespan_top #(
	parameter int unsigned MAX_MACHINES = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // [7:0] proc_time
	input  logic                          s_tuser,   // [0] new_schedule
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,   // [31:0] completion_time
	output logic                          m_tlast,   // job_done
	input  logic                          cfg_we,
	input  logic [fsmk_pkg::CfgW-1:0]     cfg_wdata
);

	localparam int unsigned IW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
	localparam int unsigned TW = fsmk_pkg::TimeW;

	logic [fsmk_pkg::CfgW-1:0] cfg_q;
	logic                      in_acc;
	logic                      out_free;
	logic                      adv;

	logic [IW-1:0]             seq_idx;
	fsmk_pkg::seq_flags_t      seq_flags;

	logic                      valid_s1;
	logic [IW-1:0]             idx_s1;
	logic [fsmk_pkg::ProcW-1:0] p_s1;
	logic                      zero_s1;
	logic                      done_s1;
	logic                      fwd_s1;
	logic [TW-1:0]             fwd_val_s1;

	logic [TW-1:0]             rd_data;
	logic [TW-1:0]             above;
	logic [TW-1:0]             left;
	logic [TW-1:0]             base;
	logic [TW:0]               sum;
	logic [TW-1:0]             c;
	logic                      fwd_hit;

	logic [MAX_MACHINES-1:0]   vld_q;
	logic [TW-1:0]             left_q;
	logic                      out_valid_q;
	logic [TW-1:0]             out_c_q;
	logic                      out_last_q;

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fsmk_pkg::CfgW'(1);
		end else if (cfg_we) begin
			cfg_q <= cfg_wdata;
		end
	end

	fsmk_seq #(
		.MAX_MACHINES(MAX_MACHINES)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_acc),
		.restart      (s_tuser),
		.machine_count(cfg_q),
		.idx          (seq_idx),
		.flags        (seq_flags)
	);

	fsmk_ram #(
		.WIDTH(TW),
		.DEPTH(MAX_MACHINES)
	) u_row (
		.clk  (clk),
		.we   (adv),
		.waddr(idx_s1),
		.wdata(c),
		.re   (in_acc),
		.raddr(seq_idx),
		.rdata(rd_data)
	);

	// entry written at the same edge as this read: take the new value
	assign fwd_hit = adv && (idx_s1 == seq_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			idx_s1     <= seq_idx;
			p_s1       <= s_tdata;
			done_s1    <= seq_flags.done;
			zero_s1    <= seq_flags.first || (!vld_q[seq_idx] && !fwd_hit);
			fwd_s1     <= fwd_hit;
			fwd_val_s1 <= c;
		end
	end

	always_comb begin
		if (zero_s1) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwd_val_s1;
		end else begin
			above = rd_data;
		end
		left = (idx_s1 == '0) ? '0 : left_q;
		base = (above > left) ? above : left;
		sum  = {1'b0, base} + (TW + 1)'(p_s1);
		c    = sum[TW] ? fsmk_pkg::TimeMax : sum[TW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			left_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				vld_q[idx_s1] <= 1'b1;
				left_q        <= c;
			end
			if (out_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_c_q    <= c;
			out_last_q <= done_s1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_c_q;
	assign m_tlast  = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(fwd_hit && in_acc) |=> (fwd_s1 && (zero_s1 == $past(seq_flags.first))))
		else $error("forwarding not captured");

	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> vld_q[$past(idx_s1)])
		else $error("row entry not marked valid after write");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(idx_s1) && $stable(p_s1)))
		else $error("read stage lost its item during output stall");

	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q && m_tready && valid_s1) |-> (idx_s1 == '0))
		else $error("operation after job end not at machine 0");

endmodule
